// ===== src/rpcb_pkg.sv =====
// Shared constants, types and helpers for the ray pair coalescing batcher.
`timescale 1ns / 1ps
`default_nettype none
package rpcb_pkg;

    localparam int CAPACITY    = 8;
    // Node size must be a power of two: quantizing is a shift of the magnitude.
    localparam int NODE_SIZE   = 8;
    localparam int NODE_SHIFT  = $clog2(NODE_SIZE);
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W      = $clog2(CAPACITY + 1);
    localparam int COORD_W     = 16;
    localparam int POINT_W     = 3 * COORD_W;
    localparam int CNT_W       = 8;
    localparam int SEQ_W       = 16;
    localparam int ML_W        = 8;
    localparam int BL_W        = 4;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 120;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_FLUSH
    } state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MERGE_LIMIT  = 1'b0,
        REG_BATCH_LENGTH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic append;
        logic flush_load;
    } cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic scan_last;
        logic absorb;
        logic flush_due;
        logic out_free;
        logic flush_last;
    } stat_t;

    // Signed divide by NODE_SIZE, truncating toward zero.
    function automatic logic [COORD_W-1:0] quant(input logic [COORD_W-1:0] v);
        logic [COORD_W:0] mag;
        logic [COORD_W:0] q;
        mag = v[COORD_W-1] ? ((COORD_W+1)'(0) - {v[COORD_W-1], v}) : {1'b0, v};
        q = mag >> NODE_SHIFT;
        if (v[COORD_W-1]) begin
            quant = COORD_W'((COORD_W+1)'(0) - q);
        end else begin
            quant = q[COORD_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/rpcb_ctrl.sv =====
// Controller state machine: capture, scan, append and flush sequencing.
`timescale 1ns / 1ps
`default_nettype none
module rpcb_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire rpcb_pkg::stat_t stat,
    output rpcb_pkg::cmd_t     cmd
);
    import rpcb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (stat.fill_zero) begin
                    state_next = ST_APPEND;
                end else if (stat.absorb) begin
                    state_next = ST_IDLE;
                end else if (stat.scan_last) begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                state_next = stat.flush_due ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH: begin
                if (stat.out_free && stat.flush_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // hold off input while reset is applied
                s_tready    = aresetn;
                cmd.capture = s_tvalid;
            end
            ST_SCAN: begin
                cmd.scan_step = !stat.fill_zero;
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
            end
            ST_FLUSH: begin
                cmd.flush_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/rpcb_datapath.sv =====
// Datapath: entry stores, match and count update, fill and sequence, output register.
`timescale 1ns / 1ps
`default_nettype none
module rpcb_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [rpcb_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic [rpcb_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tvalid,
    output logic                                   m_tlast,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_we,
    input  wire logic [rpcb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rpcb_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire rpcb_pkg::cmd_t                    cmd,
    output rpcb_pkg::stat_t                        stat
);
    import rpcb_pkg::*;

    logic [POINT_W-1:0] start_mem [CAPACITY];
    logic [POINT_W-1:0] end_mem   [CAPACITY];
    logic [CNT_W-1:0]   cnt_mem   [CAPACITY];

    logic [POINT_W-1:0] in_start_reg;
    logic [POINT_W-1:0] in_end_reg;
    logic [POINT_W-1:0] q_start_reg;
    logic [POINT_W-1:0] q_end_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic [ML_W-1:0]    merge_limit_reg;
    logic [BL_W-1:0]    batch_length_reg;
    logic               m_tvalid_reg;
    logic               m_tlast_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic [POINT_W-1:0] rd_start;
    logic [POINT_W-1:0] rd_end;
    logic [POINT_W-1:0] q_rd_start;
    logic [POINT_W-1:0] q_rd_end;
    logic [POINT_W-1:0] q_in_start;
    logic [POINT_W-1:0] q_in_end;
    logic [CNT_W-1:0]   cnt_rd;
    logic [CNT_W-1:0]   cnt_inc;
    logic               match;
    logic               at_last;
    logic [FILL_W-1:0]  fill_inc;
    logic [IDX_W-1:0]   wr_idx;

    assign rd_start = start_mem[idx_reg];
    assign rd_end   = end_mem[idx_reg];
    assign cnt_rd   = cnt_mem[idx_reg];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q_rd_start[k*COORD_W +: COORD_W] = quant(rd_start[k*COORD_W +: COORD_W]);
            q_rd_end[k*COORD_W +: COORD_W]   = quant(rd_end[k*COORD_W +: COORD_W]);
            q_in_start[k*COORD_W +: COORD_W] = quant(s_tdata[k*COORD_W +: COORD_W]);
            q_in_end[k*COORD_W +: COORD_W]   = quant(s_tdata[POINT_W + k*COORD_W +: COORD_W]);
        end
    end

    assign match    = (q_rd_start == q_start_reg) && (q_rd_end == q_end_reg);
    assign cnt_inc  = (cnt_rd == {CNT_W{1'b1}}) ? cnt_rd : cnt_rd + CNT_W'(1);
    assign at_last  = (FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg;
    assign fill_inc = fill_reg + FILL_W'(1);
    assign wr_idx   = fill_reg[IDX_W-1:0];

    always_comb begin
        stat.fill_zero  = (fill_reg == '0);
        stat.scan_last  = at_last;
        stat.absorb     = match && (cnt_inc < merge_limit_reg);
        stat.flush_due  = (16'(fill_inc) >= 16'(CAPACITY)) ||
                          (16'(fill_inc) >= 16'(batch_length_reg));
        stat.out_free   = !m_tvalid_reg || m_tready;
        stat.flush_last = at_last;
    end

    // Entry stores, captured item and output word: no reset.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_start_reg <= s_tdata[POINT_W-1:0];
            in_end_reg   <= s_tdata[2*POINT_W-1:POINT_W];
            q_start_reg  <= q_in_start;
            q_end_reg    <= q_in_end;
        end
        if (cmd.scan_step && match) begin
            cnt_mem[idx_reg] <= cnt_inc;
        end
        if (cmd.append) begin
            start_mem[wr_idx] <= in_start_reg;
            end_mem[wr_idx]   <= in_end_reg;
            cnt_mem[wr_idx]   <= CNT_W'(1);
        end
        if (cmd.flush_load) begin
            m_tdata_reg <= {seq_reg, cnt_rd, rd_end, rd_start};
            m_tlast_reg <= at_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg          <= '0;
            fill_reg         <= '0;
            seq_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
            merge_limit_reg  <= ML_W'(4);
            batch_length_reg <= BL_W'(4);
        end else begin
            if (cmd.capture || cmd.append) begin
                idx_reg <= '0;
            end else if ((cmd.scan_step && !stat.absorb) || cmd.flush_load) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (cmd.append) begin
                fill_reg <= fill_inc;
                if (stat.flush_due) seq_reg <= seq_reg + SEQ_W'(1);
            end else if (cmd.flush_load && at_last) begin
                fill_reg <= '0;
            end

            if (cmd.flush_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MERGE_LIMIT:  merge_limit_reg  <= cfg_wdata[ML_W-1:0];
                    REG_BATCH_LENGTH: batch_length_reg <= cfg_wdata[BL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

// ===== src/ray_pair_coalescing_batcher_unit.sv =====
// Top level of the ray pair coalescing batcher: controller plus datapath.
//
//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   s_tdata: start_x..end_z
//  m_        out  m_tvalid/m_tready   m_tdata: out_start_x..batch_seq, m_tlast
//  cfg_      in   cfg_we              cfg_index, cfg_wdata
//
// An item is captured, then compared against each buffered entry in turn;
// an absorbed item ends at its match. An item that is not absorbed is
// appended, after which a flush, when due, sends one word a cycle
// while m_tready is high, up to CAPACITY words, all from the single entry
// read port. Reset is synchronous, active low, and empties the buffer.
// A stalled m_tready holds the flush; s_tready is high only between items.
`timescale 1ns / 1ps
`default_nettype none
module ray_pair_coalescing_batcher_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  wire logic [rpcb_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_start_x, out_start_y, out_start_z, out_end_x, out_end_y, out_end_z,
    // merge_count, batch_seq
    output logic [rpcb_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [rpcb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rpcb_pkg::CFG_W-1:0]        cfg_wdata
);
    import rpcb_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rpcb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rpcb_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tlast   (m_tlast),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    // No datapath work while the input side is open.
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(cmd.scan_step || cmd.append || cmd.flush_load))
        else $error("datapath command while accepting input");

    // Never overwrite a word that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush_load |-> (!m_tvalid || m_tready))
        else $error("output word overwritten");

    // The final flushed word leaves the buffer empty and carries tlast.
    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.flush_load && stat.flush_last) |=> (stat.fill_zero && m_tvalid && m_tlast))
        else $error("buffer not emptied after flush");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for the ray pair coalescing batcher: directed, saturation, random runs.
`timescale 1ns / 1ps
module tb;
    import rpcb_pkg::*;

    localparam int RAY_W = IN_TDATA_W;

    // One input ray; start_x sits in the lowest bits of s_tdata.
    typedef struct packed {
        logic signed [COORD_W-1:0] end_z;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_x;
    } ray_t;

    typedef struct {
        logic [RAY_W-1:0] ray;
        logic [CNT_W-1:0] count;
        logic [SEQ_W-1:0] seq;
        logic             last;
    } batch_out_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [RAY_W-1:0]       s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_MERGE_LIMIT;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    // Shadow of the block: buffered rays, their merge counts, fill, batch number, registers
    logic [RAY_W-1:0] buf_ray[CAPACITY];
    logic [CNT_W-1:0] buf_count[CAPACITY];
    int               buf_fill    = 0;
    logic [SEQ_W-1:0] batch_seq_q = '0;
    logic [ML_W-1:0]  merge_limit = 8'd4;
    logic [BL_W-1:0]  batch_len   = 4'd4;

    batch_out_t flush_words[$];
    int         fail_cnt = 0;
    bit         no_idle  = 1'b0;
    string      coord_names[6] = '{"out_start_x", "out_start_y", "out_start_z",
                                   "out_end_x", "out_end_y", "out_end_z"};

    ray_pair_coalescing_batcher_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // Quantized coordinate: divide by node size, truncating toward zero.
    function automatic int cell_of(input logic signed [COORD_W-1:0] v);
        return int'(v) / NODE_SIZE;
    endfunction

    function automatic bit same_cell(input logic [RAY_W-1:0] a, input logic [RAY_W-1:0] b);
        for (int k = 0; k < 6; k++) begin
            if (cell_of(a[COORD_W*k +: COORD_W]) != cell_of(b[COORD_W*k +: COORD_W]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_pair(input logic [RAY_W-1:0] r);
        batch_out_t w;
        for (int i = 0; i < buf_fill; i++) begin
            if (same_cell(r, buf_ray[i])) begin
                if (buf_count[i] != 8'hFF)
                    buf_count[i]++;
                // absorb on the first match still under the limit
                if (buf_count[i] < merge_limit)
                    return;
            end
        end
        buf_ray[buf_fill]   = r;
        buf_count[buf_fill] = 8'd1;
        buf_fill++;
        if (buf_fill < CAPACITY && buf_fill < int'(batch_len))
            return;
        batch_seq_q++;
        for (int i = 0; i < buf_fill; i++) begin
            w.ray   = buf_ray[i];
            w.count = buf_count[i];
            w.seq   = batch_seq_q;
            w.last  = (i == buf_fill - 1);
            flush_words.push_back(w);
        end
        buf_fill = 0;
    endfunction

    // Random coordinate in the same cell as v; the cell around zero spans both signs.
    function automatic logic [COORD_W-1:0] jitter_coord(input logic signed [COORD_W-1:0] v);
        int q, lo, hi;
        q  = cell_of(v);
        lo = (q > 0) ? q * NODE_SIZE : q * NODE_SIZE - (NODE_SIZE - 1);
        hi = (q < 0) ? q * NODE_SIZE : q * NODE_SIZE + (NODE_SIZE - 1);
        if (lo < -32768)
            lo = -32768;
        if (hi > 32767)
            hi = 32767;
        return COORD_W'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(7))
            0: return COORD_W'(int'($urandom_range(40)) - 20);
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAY_W-1:0] rand_ray();
        logic [RAY_W-1:0] r;
        for (int k = 0; k < 6; k++)
            r[COORD_W*k +: COORD_W] = rand_coord();
        return r;
    endfunction

    function automatic logic [RAY_W-1:0] jitter_ray(input logic [RAY_W-1:0] base);
        logic [RAY_W-1:0] r;
        for (int k = 0; k < 6; k++)
            r[COORD_W*k +: COORD_W] = jitter_coord(base[COORD_W*k +: COORD_W]);
        return r;
    endfunction

    // Move one coordinate by a node size: usually lands in the next cell.
    function automatic logic [RAY_W-1:0] nudge_ray(input logic [RAY_W-1:0] base);
        logic [RAY_W-1:0] r;
        int k;
        r = base;
        k = $urandom_range(5);
        if ($urandom_range(1))
            r[COORD_W*k +: COORD_W] = r[COORD_W*k +: COORD_W] + COORD_W'(NODE_SIZE);
        else
            r[COORD_W*k +: COORD_W] = r[COORD_W*k +: COORD_W] - COORD_W'(NODE_SIZE);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns %s: expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    // Leaves s_tvalid high after the handshake; the next call or a register write
    // lowers it or replaces the word in the same step.
    task automatic send_pair(input logic [RAY_W-1:0] r);
        if (!no_idle && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 28);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do @(posedge aclk); while (!s_tready);
        predict_pair(r);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        while (flush_words.size() != 0)
            @(posedge aclk);
        // let an absorbing item finish its scan
        repeat (30) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_MERGE_LIMIT)
            merge_limit = val;
        else
            batch_len = val[BL_W-1:0];
    endtask

    task automatic drain_batch();
        while (buf_fill != 0)
            send_pair(rand_ray());
    endtask

    task automatic test_directed();
        ray_t a, b, c, d, e;
        a = '{start_x: 16'h8000, start_y: 16'h7FFF, start_z: 16'h0000,
              end_x: 16'h7FFF, end_y: 16'h8000, end_z: 16'hFFFF};
        // same cells as a: 7 and 1 truncate to the zero cell like 0 and -1
        b = a;
        b.start_y = 16'h7FF8;
        b.start_z = 16'sd7;
        b.end_z   = 16'sd1;
        // one cell off: -8 is the first value past the zero cell
        c = a;
        c.start_z = -16'sd8;
        d = '{default: 16'h7FFF};
        e = '{default: 16'h8000};
        send_pair(a);
        send_pair(b);
        send_pair(c);
        send_pair(a);
        // count reaches the limit: append instead of absorb, fill hits the batch length
        send_pair(b);
        send_pair(d);
        // merge limit zero and batch length zero or one: each pair flushes at once
        write_reg(REG_MERGE_LIMIT, 8'd0);
        write_reg(REG_BATCH_LENGTH, 8'd0);
        send_pair(a);
        send_pair(e);
        write_reg(REG_BATCH_LENGTH, 8'd1);
        send_pair(c);
        // batch length above capacity: flush at capacity, earlier entries count higher
        write_reg(REG_BATCH_LENGTH, 8'd15);
        repeat (CAPACITY) send_pair(jitter_ray(a));
    endtask

    task automatic test_saturation();
        logic [RAY_W-1:0] base;
        write_reg(REG_MERGE_LIMIT, 8'd255);
        write_reg(REG_BATCH_LENGTH, 8'd8);
        base = rand_ray();
        // drive one entry to 255, then keep hitting it
        repeat (270) send_pair(jitter_ray(base));
        drain_batch();
    endtask

    task automatic test_random();
        logic [CFG_W-1:0] ml_tab[6] = '{8'd1, 8'd2, 8'd255, 8'd0, 8'd3, 8'd4};
        logic [CFG_W-1:0] bl_tab[6] = '{8'd8, 8'd3, 8'd8, 8'd5, 8'd1, 8'd6};
        logic [RAY_W-1:0] pool[6];
        logic [RAY_W-1:0] r;
        int pick, roll;
        for (int p = 0; p < 6; p++) begin
            if (p == 5) begin
                write_reg(REG_MERGE_LIMIT, CFG_W'($urandom_range(2, 8)));
                write_reg(REG_BATCH_LENGTH, CFG_W'($urandom_range(2, 8)));
            end else begin
                write_reg(REG_MERGE_LIMIT, ml_tab[p]);
                write_reg(REG_BATCH_LENGTH, bl_tab[p]);
            end
            no_idle = (p == 5);
            foreach (pool[i])
                pool[i] = rand_ray();
            repeat (32) begin
                pick = $urandom_range(5);
                roll = $urandom_range(99);
                if (roll < 55) begin
                    r = jitter_ray(pool[pick]);
                end else if (roll < 70) begin
                    r = nudge_ray(pool[pick]);
                end else if (roll < 80) begin
                    pool[pick] = rand_ray();
                    r = pool[pick];
                end else begin
                    r = rand_ray();
                end
                send_pair(r);
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: check each accepted word and stall at random.
    always @(posedge aclk) begin : check_results
        batch_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (flush_words.size() == 0) begin
                $display("%0t ns unexpected word: expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                fail_cnt++;
            end else begin
                want = flush_words.pop_front();
                for (int k = 0; k < 6; k++)
                    check_field(coord_names[k], want.ray[COORD_W*k +: COORD_W],
                                m_tdata[COORD_W*k +: COORD_W]);
                check_field("merge_count", 16'(want.count), 16'(m_tdata[2*POINT_W +: CNT_W]));
                check_field("batch_seq", want.seq, m_tdata[2*POINT_W+CNT_W +: SEQ_W]);
                check_field("last_of_batch", 16'(want.last), 16'(m_tlast));
            end
        end
        m_tready <= no_idle || ($urandom_range(99) >= 28);
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_saturation();
        test_random();
        // flush what is still buffered
        write_reg(REG_BATCH_LENGTH, 8'd1);
        drain_batch();
        s_tvalid <= 1'b0;
        while (flush_words.size() != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_cnt == 0 && flush_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/rpcb_pkg.sv
src/rpcb_ctrl.sv
src/rpcb_datapath.sv
src/ray_pair_coalescing_batcher_unit.sv
sim/tb.sv
